// ===== sv/tpq_pkg.sv =====
// ---------------------------------------------------------------------------
// Time window packet queue package
// Shared constants, register indexes and types for the packet queue.
// ---------------------------------------------------------------------------
`default_nettype none

package tpq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int STAMP_BITS  = 48;
  localparam int LEN_W       = 26;
  localparam int REG_W       = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TOTAL_W     = LEN_W + IDX_W + 1;
  localparam int CFG_IDX_W   = 1;

  localparam logic [REG_W-1:0] DURATION_RESET = 32'd10000;
  localparam logic [REG_W-1:0] CAP_RESET      = 32'd52428800;

  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAP      = 1'd1;

  localparam logic MODE_PUSH  = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TIME,
    ST_CAP
  } tpq_state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/tpq_packet_if.sv =====
// ---------------------------------------------------------------------------
// Packet descriptor channel
// Valid/ready channel carrying one queue command per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface tpq_packet_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [tpq_pkg::LEN_W-1:0]      packet_bytes;
  logic [tpq_pkg::STAMP_BITS-1:0] timestamp_ms;

  modport source (output valid, output mode, output packet_bytes, output timestamp_ms,
                  input ready);
  modport sink (input valid, input mode, input packet_bytes, input timestamp_ms,
                output ready);
endinterface

`default_nettype wire

// ===== sv/tpq_status_if.sv =====
// ---------------------------------------------------------------------------
// Queue status channel
// Valid/ready channel carrying one queue status report per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface tpq_status_if;
  logic                           valid;
  logic                           ready;
  logic [tpq_pkg::CNT_W-1:0]      entry_count;
  logic [tpq_pkg::REG_W-1:0]      total_bytes;
  logic [tpq_pkg::STAMP_BITS-1:0] span_ms;
  logic [tpq_pkg::CNT_W-1:0]      dropped_count;
  logic                           cap_dropped;
  logic                           overflow_dropped;

  modport source (output valid, output entry_count, output total_bytes, output span_ms,
                  output dropped_count, output cap_dropped, output overflow_dropped,
                  input ready);
  modport sink (input valid, input entry_count, input total_bytes, input span_ms,
                input dropped_count, input cap_dropped, input overflow_dropped,
                output ready);
endinterface

`default_nettype wire

// ===== sv/tpq_cell.sv =====
// ---------------------------------------------------------------------------
// Queue cell
// One descriptor slot of the shifting queue: loads a new descriptor or takes
// the descriptor of the cell behind it when the head is popped.
// ---------------------------------------------------------------------------
`default_nettype none

module tpq_cell (
  input  wire                              clk,
  input  wire  tpq_pkg::cell_ctrl_t        ctrl,
  input  wire  [tpq_pkg::STAMP_BITS-1:0]   new_stamp,
  input  wire  [tpq_pkg::LEN_W-1:0]        new_len,
  input  wire  [tpq_pkg::STAMP_BITS-1:0]   next_stamp,
  input  wire  [tpq_pkg::LEN_W-1:0]        next_len,
  output logic [tpq_pkg::STAMP_BITS-1:0]   stamp,
  output logic [tpq_pkg::LEN_W-1:0]        len
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      stamp <= new_stamp;
      len   <= new_len;
    end else if (ctrl.shift) begin
      stamp <= next_stamp;
      len   <= next_len;
    end
  end

endmodule

`default_nettype wire

// ===== sv/time_window_packet_queue_core.sv =====
// ---------------------------------------------------------------------------
// Time window packet queue core
// FIFO of packet descriptors pruned by age and by a byte cap.
// ---------------------------------------------------------------------------
// A push on the packet channel appends a descriptor to a row of cells; the
// head always sits in cell zero and every pop shifts the row by one cell.
// A clear empties the queue at once. Each beat accepted on the packet channel
// produces exactly one beat on the status channel.
// Pruning compares and pops the head, one entry per cycle: a push first drops
// entries by age and then by the byte cap, while a clear goes straight to the
// cap step, then reports its result. A new beat is
// accepted only once the previous one has finished pruning, but a status
// beat waiting in the output register does not block the next acceptance.
// If the receiver stalls, the finished result is held in the controller
// until the output register frees up.
// Reset empties the queue and loads the duration with 10000 ms, the cap with
// 52428800 bytes. Users must write registers with cfg_we while idle; not enforced.
// ---------------------------------------------------------------------------
`default_nettype none

module time_window_packet_queue_core (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire  [tpq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [tpq_pkg::REG_W-1:0]          cfg_data,
  tpq_packet_if.sink                         packet,
  tpq_status_if.source                       status
);

  tpq_pkg::tpq_state_t state, state_next;

  logic [tpq_pkg::REG_W-1:0]      max_duration;
  logic [tpq_pkg::REG_W-1:0]      byte_cap;
  logic [tpq_pkg::CNT_W-1:0]      count;
  logic [tpq_pkg::TOTAL_W-1:0]    total;
  logic [tpq_pkg::STAMP_BITS-1:0] newest;
  logic [tpq_pkg::CNT_W-1:0]      dropped;
  logic                           cap_hit;
  logic                           overflow;

  logic [tpq_pkg::STAMP_BITS-1:0] cell_stamp [tpq_pkg::QUEUE_DEPTH];
  logic [tpq_pkg::LEN_W-1:0]      cell_len   [tpq_pkg::QUEUE_DEPTH];
  tpq_pkg::cell_ctrl_t            cell_ctrl  [tpq_pkg::QUEUE_DEPTH];

  logic                           accept;
  logic                           push;
  logic                           full;
  logic [tpq_pkg::IDX_W-1:0]      tail;
  logic                           pop;
  logic                           load_result;
  logic                           out_free;
  logic [tpq_pkg::STAMP_BITS:0]   diff;
  logic                           too_old;
  logic                           over_cap;

  assign accept   = packet.valid && packet.ready;
  assign push     = accept && (packet.mode == tpq_pkg::MODE_PUSH);
  assign full     = (count == tpq_pkg::CNT_W'(tpq_pkg::QUEUE_DEPTH));
  assign tail     = full ? tpq_pkg::IDX_W'(tpq_pkg::QUEUE_DEPTH - 1)
                         : count[tpq_pkg::IDX_W-1:0];
  assign out_free = !status.valid || status.ready;
  assign diff     = {1'b0, newest} - {1'b0, cell_stamp[0]};
  assign too_old  = (count != '0) && !diff[tpq_pkg::STAMP_BITS] &&
                    (diff[tpq_pkg::STAMP_BITS-1:0] >
                     tpq_pkg::STAMP_BITS'(max_duration));
  assign over_cap = (count != '0) && (total > tpq_pkg::TOTAL_W'(byte_cap));

  always_comb begin
    state_next = state;
    case (state)
      tpq_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (packet.mode == tpq_pkg::MODE_CLEAR) ? tpq_pkg::ST_CAP
                                                            : tpq_pkg::ST_TIME;
        end
      end
      tpq_pkg::ST_TIME: begin
        if (!too_old) begin
          state_next = tpq_pkg::ST_CAP;
        end
      end
      tpq_pkg::ST_CAP: begin
        if (!over_cap && out_free) begin
          state_next = tpq_pkg::ST_IDLE;
        end
      end
      default: state_next = tpq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    packet.ready = 1'b0;
    pop          = 1'b0;
    load_result  = 1'b0;
    case (state)
      tpq_pkg::ST_IDLE: packet.ready = 1'b1;
      tpq_pkg::ST_TIME: pop = too_old;
      tpq_pkg::ST_CAP: begin
        pop         = over_cap;
        load_result = !over_cap && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_duration <= tpq_pkg::DURATION_RESET;
      byte_cap     <= tpq_pkg::CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tpq_pkg::REG_DURATION: max_duration <= cfg_data;
        tpq_pkg::REG_CAP:      byte_cap     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      total    <= '0;
      dropped  <= '0;
      cap_hit  <= 1'b0;
      overflow <= 1'b0;
    end else if (accept) begin
      dropped <= '0;
      cap_hit <= 1'b0;
      if (packet.mode == tpq_pkg::MODE_CLEAR) begin
        count    <= '0;
        total    <= '0;
        overflow <= 1'b0;
      end else begin
        count    <= full ? count : count + tpq_pkg::CNT_W'(1);
        total    <= total - (full ? tpq_pkg::TOTAL_W'(cell_len[0]) : '0)
                    + tpq_pkg::TOTAL_W'(packet.packet_bytes);
        overflow <= full;
      end
    end else if (pop) begin
      count   <= count - tpq_pkg::CNT_W'(1);
      total   <= total - tpq_pkg::TOTAL_W'(cell_len[0]);
      dropped <= dropped + tpq_pkg::CNT_W'(1);
      if (state == tpq_pkg::ST_CAP) begin
        cap_hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      newest <= packet.timestamp_ms;
    end
  end

  always_comb begin
    for (int i = 0; i < tpq_pkg::QUEUE_DEPTH; i++) begin
      cell_ctrl[i].load  = push && (tail == tpq_pkg::IDX_W'(i));
      cell_ctrl[i].shift = pop || (push && full);
    end
  end

  for (genvar i = 0; i < tpq_pkg::QUEUE_DEPTH; i++) begin : g_cell
    if (i < tpq_pkg::QUEUE_DEPTH - 1) begin : g_mid
      tpq_cell u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[i]),
        .new_stamp  (packet.timestamp_ms),
        .new_len    (packet.packet_bytes),
        .next_stamp (cell_stamp[i+1]),
        .next_len   (cell_len[i+1]),
        .stamp      (cell_stamp[i]),
        .len        (cell_len[i])
      );
    end else begin : g_last
      tpq_cell u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[i]),
        .new_stamp  (packet.timestamp_ms),
        .new_len    (packet.packet_bytes),
        .next_stamp (packet.timestamp_ms),
        .next_len   (packet.packet_bytes),
        .stamp      (cell_stamp[i]),
        .len        (cell_len[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status.valid <= 1'b0;
    end else if (load_result) begin
      status.valid <= 1'b1;
    end else if (status.ready) begin
      status.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      status.entry_count      <= count;
      status.total_bytes      <= total[tpq_pkg::REG_W-1:0];
      status.span_ms          <= ((count != '0) && !diff[tpq_pkg::STAMP_BITS])
                                 ? diff[tpq_pkg::STAMP_BITS-1:0] : '0;
      status.dropped_count    <= dropped;
      status.cap_dropped      <= cap_hit;
      status.overflow_dropped <= overflow;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= tpq_pkg::CNT_W'(tpq_pkg::QUEUE_DEPTH))
    else $error("queue holds more descriptors than cells");

  a_empty_total: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> total == '0)
    else $error("byte total nonzero on an empty queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from an empty queue");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !packet.ready)
    else $error("new beat accepted before pruning finished");

  a_result_after_prune: assert property (@(posedge clk) disable iff (rst)
    load_result |-> !over_cap && state == tpq_pkg::ST_CAP)
    else $error("status loaded while pruning still pending");

endmodule

`default_nettype wire
